@@ design/dbel_pkg.sv @@
// Shared types and constants for the debounced edge event logger.
// Used by the debounce front end, the top level and the testbench; no dependencies.
package dbel_pkg;

	// Configuration register indexes.
	localparam logic [0:0] REG_DEBOUNCE   = 1'b0;
	localparam logic [0:0] REG_TIME_FLOOR = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [15:0] DEBOUNCE_RESET = 16'd40;
	localparam logic [33:0] FLOOR_RESET    = 34'd1700000000;

	// Input selector codes.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_DUMP   = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_EVENT  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ROW    = 2'd2;

	// Readout sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EVENT  = 4'b0010,
		ST_HEADER = 4'b0100,
		ST_ROWS   = 4'b1000
	} dbel_state_t;

	// Decision of the debounce front end for one sample.
	typedef struct packed {
		logic commit;
		logic old_level;
		logic new_level;
	} dbel_commit_t;

	// Flags stored with every history entry.
	typedef struct packed {
		logic pulse;
		logic relay;
		logic valid;
		logic new_level;
		logic old_level;
	} dbel_flags_t;

	// One history entry as held in the ring RAM.
	typedef struct packed {
		dbel_flags_t  flags;
		logic [33:0]  seconds;
		logic [31:0]  uptime;
		logic [31:0]  id;
	} hist_entry_t;

	// Result payload as laid out on the output data bus, lowest field last.
	typedef struct packed {
		logic [3:0]  pad;
		logic [4:0]  stored_count;
		logic [31:0] total_events;
		logic        pulse_at_event;
		logic        relay_at_event;
		logic        stamp_valid;
		logic [33:0] stamp_seconds;
		logic [31:0] stamp_ms;
		logic        new_level;
		logic        old_level;
		logic [31:0] seq_id;
	} dbel_out_t;

	// Builds the payload of a live event or a history row from an entry.
	function automatic dbel_out_t row_from_entry(hist_entry_t e);
		dbel_out_t r;
		r                = '0;
		r.seq_id         = e.id;
		r.old_level      = e.flags.old_level;
		r.new_level      = e.flags.new_level;
		r.stamp_ms       = e.uptime;
		r.stamp_seconds  = e.seconds;
		r.stamp_valid    = e.flags.valid;
		r.relay_at_event = e.flags.relay;
		r.pulse_at_event = e.flags.pulse;
		return r;
	endfunction

endpackage

@@ design/dbel_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module dbel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/dbel_debounce.sv @@
// Debounce front end: tracks the raw and stable levels and the settle timer.
// Depends on dbel_pkg for the commit decision struct.
module dbel_debounce (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_en,
	input  logic [31:0]           now_ms,
	input  logic                  raw_level,
	input  logic [15:0]           debounce_ms,
	output dbel_pkg::dbel_commit_t decision
);

	import dbel_pkg::*;

	logic        stable_q;
	logic        seen_q;
	logic [31:0] last_change_q;
	logic        raw_changed;
	logic [31:0] change_ms;
	logic [31:0] elapsed;

	// A raw change restarts the timer at this sample's uptime.
	assign raw_changed = (raw_level != seen_q);
	assign change_ms   = raw_changed ? now_ms : last_change_q;
	assign elapsed     = now_ms - change_ms;

	// The new level is committed once it differs from the stable one and has held.
	always_comb begin
		decision.commit    = (raw_level != stable_q) && (elapsed >= {16'd0, debounce_ms});
		decision.old_level = stable_q;
		decision.new_level = raw_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b1;
			seen_q        <= 1'b1;
			last_change_q <= '0;
		end else if (sample_en) begin
			seen_q        <= raw_level;
			last_change_q <= change_ms;
			if (decision.commit) begin
				stable_q <= raw_level;
			end
		end
	end

	// A commit always moves the stable level to the sampled raw level.
	a_commit_moves_level: assert property (@(posedge clk) disable iff (!arst_n)
		sample_en && decision.commit |=> stable_q != $past(stable_q) && stable_q == seen_q)
		else $error("commit did not move the stable level");

	// Without a sample the debounce state holds.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_en |=> $stable(stable_q) && $stable(seen_q) && $stable(last_change_q))
		else $error("debounce state changed without a sample");

	// The stable level never changes to something other than the seen raw level.
	a_stable_follows_seen: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && stable_q != $past(stable_q) |-> stable_q == seen_q)
		else $error("stable level diverged from the seen raw level");

endmodule

@@ design/debounced_edge_event_logger_unit.sv @@
// Debounced edge event logger: top level with the ring history and readout.
// Depends on dbel_pkg, dbel_debounce and dbel_ram.
//
// A line sample that commits no edge leaves the block idle, so it is ready for
// the next item in the following cycle. A committed edge is written to the ring
// RAM in the cycle the sample is accepted; the block then delivers the live
// event, a header and one history row per cycle while the output is not stalled,
// oldest first, for N entries held (at most HISTORY_DEPTH), and takes no new item
// until the readout is done. A dump request delivers the header and the same rows.
// The row rate is set by the single read port of the history RAM, read one row
// ahead of the output register. The output register lets a new item be accepted
// while the last result of the previous item is still waiting to be taken.
module debounced_edge_event_logger_unit #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input items.
	input  logic         s_tvalid,
	output logic         s_tready,
	// now_ms[31:0], raw_level[32], time_synced[33], wall_seconds[67:34],
	// relay_state[68], pulse_active[69], zero padding [71:70]
	input  logic [71:0]  s_tdata,
	// func[0]
	input  logic [0:0]   s_tuser,
	// Result items.
	output logic         m_tvalid,
	input  logic         m_tready,
	// seq_id[31:0], old_level[32], new_level[33], stamp_ms[65:34],
	// stamp_seconds[99:66], stamp_valid[100], relay_at_event[101],
	// pulse_at_event[102], total_events[134:103], stored_count[139:135],
	// zero padding [143:140]
	output logic [143:0] m_tdata,
	// kind[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	// Configuration writes.
	input  logic         cfg_wr_en,
	input  logic [0:0]   cfg_index,
	input  logic [33:0]  cfg_data
);

	import dbel_pkg::*;

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(HISTORY_DEPTH);

	// Input field views.
	logic [31:0] in_now_ms;
	logic        in_raw_level;
	logic        in_time_synced;
	logic [33:0] in_wall_seconds;
	logic        in_relay_state;
	logic        in_pulse_active;
	logic        in_func;

	assign in_now_ms       = s_tdata[31:0];
	assign in_raw_level    = s_tdata[32];
	assign in_time_synced  = s_tdata[33];
	assign in_wall_seconds = s_tdata[67:34];
	assign in_relay_state  = s_tdata[68];
	assign in_pulse_active = s_tdata[69];
	assign in_func         = s_tuser[0];

	// Configuration registers.
	logic [15:0] debounce_q;
	logic [33:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			floor_q    <= FLOOR_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q <= cfg_data[15:0];
				REG_TIME_FLOOR: floor_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control and ring state.
	dbel_state_t   state_q;
	logic [AW-1:0] write_slot_q;
	logic [CW-1:0] held_q;
	logic [31:0]   next_id_q;
	logic [AW-1:0] rd_addr_q;
	logic [CW-1:0] row_q;
	hist_entry_t   event_q;

	// Output register.
	logic        m_tvalid_q;
	dbel_out_t   m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	logic          in_accept;
	logic          sample_en;
	logic          out_load;
	dbel_commit_t  decision;
	logic          commit;
	hist_entry_t   new_entry;
	logic [AW-1:0] first_slot;
	logic [AW-1:0] next_rd_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_en;
	logic          row_last;
	logic [CW+4:0] held_wide;
	dbel_out_t     header_item;
	hist_entry_t   rd_entry;
	logic [$bits(hist_entry_t)-1:0] rd_word;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign sample_en = in_accept && (in_func == FUNC_SAMPLE);
	assign out_load  = !m_tvalid_q || m_tready;

	dbel_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_en   (sample_en),
		.now_ms      (in_now_ms),
		.raw_level   (in_raw_level),
		.debounce_ms (debounce_q),
		.decision    (decision)
	);

	assign commit = sample_en && decision.commit;

	// Entry recorded for a committed edge.
	always_comb begin
		new_entry.id              = next_id_q;
		new_entry.uptime          = in_now_ms;
		new_entry.seconds         = in_wall_seconds;
		new_entry.flags.old_level = decision.old_level;
		new_entry.flags.new_level = decision.new_level;
		new_entry.flags.valid     = in_time_synced && (in_wall_seconds >= floor_q);
		new_entry.flags.relay     = in_relay_state;
		new_entry.flags.pulse     = in_pulse_active;
	end

	// Readout addressing: oldest entry first, wrapping round the ring.
	assign first_slot   = (held_q == FULL_COUNT) ? write_slot_q : '0;
	assign next_rd_addr = (rd_addr_q == LAST_SLOT) ? '0 : rd_addr_q + 1'b1;
	assign row_last     = (CW'(row_q + 1'b1) == held_q);
	assign rd_addr      = (state_q == ST_HEADER) ? first_slot : next_rd_addr;
	assign rd_en        = out_load &&
		(((state_q == ST_HEADER) && (held_q != '0)) || ((state_q == ST_ROWS) && !row_last));

	dbel_ram #(
		.WIDTH ($bits(hist_entry_t)),
		.DEPTH (HISTORY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (write_slot_q),
		.wdata (new_entry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	assign rd_entry = hist_entry_t'(rd_word);

	// Header payload.
	assign held_wide = {5'd0, held_q};
	always_comb begin
		header_item              = '0;
		header_item.total_events = next_id_q - 32'd1;
		header_item.stored_count = held_wide[4:0];
	end

	// Ring bookkeeping and the readout sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			held_q       <= '0;
			next_id_q    <= 32'd1;
			rd_addr_q    <= '0;
			row_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (in_func == FUNC_DUMP) begin
							state_q <= ST_HEADER;
						end else if (decision.commit) begin
							state_q      <= ST_EVENT;
							next_id_q    <= next_id_q + 32'd1;
							write_slot_q <= (write_slot_q == LAST_SLOT) ? '0
								: write_slot_q + 1'b1;
							if (held_q != FULL_COUNT) begin
								held_q <= held_q + 1'b1;
							end
						end
					end
				end
				ST_EVENT: begin
					if (out_load) begin
						state_q <= ST_HEADER;
					end
				end
				ST_HEADER: begin
					if (out_load) begin
						rd_addr_q <= first_slot;
						row_q     <= '0;
						state_q   <= (held_q == '0) ? ST_IDLE : ST_ROWS;
					end
				end
				ST_ROWS: begin
					if (out_load) begin
						if (row_last) begin
							state_q <= ST_IDLE;
						end else begin
							rd_addr_q <= next_rd_addr;
							row_q     <= row_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Live event payload, captured with the commit.
	always_ff @(posedge clk) begin
		if (commit) begin
			event_q <= new_entry;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= (state_q == ST_EVENT) || (state_q == ST_HEADER)
				|| (state_q == ST_ROWS);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			case (state_q)
				ST_EVENT: begin
					m_tdata_q <= row_from_entry(event_q);
					m_tuser_q <= KIND_EVENT;
					m_tlast_q <= 1'b0;
				end
				ST_HEADER: begin
					m_tdata_q <= header_item;
					m_tuser_q <= KIND_HEADER;
					m_tlast_q <= (held_q == '0);
				end
				ST_ROWS: begin
					m_tdata_q <= row_from_entry(rd_entry);
					m_tuser_q <= KIND_ROW;
					m_tlast_q <= row_last;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The fill count never exceeds the ring depth.
	a_held_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_COUNT)
		else $error("history fill count beyond ring depth");

	// A committed edge is always followed by its live event.
	a_commit_to_event: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == ST_EVENT)
		else $error("committed edge did not enter the event state");

	// Rows are only read out when the history holds something.
	a_rows_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROWS |-> held_q != '0 && row_q < held_q)
		else $error("row readout outside the held entries");

	// The ring is never written while a readout is in progress.
	a_no_write_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> state_q == ST_IDLE)
		else $error("history written during readout");

endmodule

@@ tb/tb_debounced_edge_event_logger_unit.sv @@
// Self-checking testbench for debounced_edge_event_logger_unit: directed and random line
// samples and dump requests, checked against an in-bench model of debounce and ring history.
// Depends on dbel_pkg and the design top level only.
module tb_debounced_edge_event_logger_unit;

	import dbel_pkg::*;

	localparam int DEPTH         = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES  = 30;
	localparam int STALL_LIMIT   = 4000;

	// One input item as the sender sees it.
	typedef struct {
		logic        func;
		logic [31:0] now_ms;
		logic        raw;
		logic        synced;
		logic [33:0] wall;
		logic        relay;
		logic        pulse;
	} sample_t;

	// One result item as the checker expects it.
	typedef struct {
		logic [1:0] kind;
		dbel_out_t  body;
		logic       last;
	} log_result_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata   = '0;
	logic [0:0]   s_tuser   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_wr_en = 1'b0;
	logic [0:0]   cfg_index = '0;
	logic [33:0]  cfg_data  = '0;

	// Shared control between the stimulus and the receiver.
	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	// Line model state used to shape well-formed random traffic.
	logic [31:0] line_clock  = '0;
	logic        line_target = 1'b1;

	// Predicted state of the block.
	logic [15:0] debounce_cfg = DEBOUNCE_RESET;
	logic [33:0] floor_cfg    = FLOOR_RESET;
	logic        stable_lvl   = 1'b1;
	logic        seen_lvl     = 1'b1;
	logic [31:0] changed_at   = '0;
	int          wr_slot      = 0;
	int          held         = 0;
	logic [31:0] next_seq     = 32'd1;
	logic [31:0] hist_id    [DEPTH];
	logic [31:0] hist_ms    [DEPTH];
	logic [33:0] hist_secs  [DEPTH];
	dbel_flags_t hist_flags [DEPTH];

	log_result_t expected_log[$];

	debounced_edge_event_logger_unit #(
		.HISTORY_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Builds a live event or history row from one stored entry.
	function automatic log_result_t entry_result(logic [1:0] kind, int slot);
		log_result_t r;
		r.kind                = kind;
		r.last                = 1'b0;
		r.body                = '0;
		r.body.seq_id         = hist_id[slot];
		r.body.old_level      = hist_flags[slot].old_level;
		r.body.new_level      = hist_flags[slot].new_level;
		r.body.stamp_ms       = hist_ms[slot];
		r.body.stamp_seconds  = hist_secs[slot];
		r.body.stamp_valid    = hist_flags[slot].valid;
		r.body.relay_at_event = hist_flags[slot].relay;
		r.body.pulse_at_event = hist_flags[slot].pulse;
		return r;
	endfunction

	// Queues the header and every held entry, oldest first.
	task automatic queue_history();
		log_result_t hdr;
		log_result_t row;
		int          first;
		hdr.kind              = KIND_HEADER;
		hdr.body              = '0;
		hdr.body.total_events = next_seq - 32'd1;
		hdr.body.stored_count = 5'(held);
		hdr.last              = (held == 0);
		expected_log.push_back(hdr);
		first = (held >= DEPTH) ? wr_slot : 0;
		for (int i = 0; i < held; i++) begin
			row      = entry_result(KIND_ROW, (first + i) % DEPTH);
			row.last = (i == held - 1);
			expected_log.push_back(row);
		end
	endtask

	// Advances the debounce and history model by one accepted item.
	task automatic predict_sample(sample_t s);
		logic [31:0] held_for;
		dbel_flags_t f;
		if (s.func == FUNC_DUMP) begin
			queue_history();
			return;
		end
		if (s.raw != seen_lvl) begin
			seen_lvl   = s.raw;
			changed_at = s.now_ms;
		end
		held_for = s.now_ms - changed_at;
		if (seen_lvl == stable_lvl || held_for < {16'd0, debounce_cfg})
			return;
		f.old_level = stable_lvl;
		f.new_level = seen_lvl;
		f.valid     = s.synced && (s.wall >= floor_cfg);
		f.relay     = s.relay;
		f.pulse     = s.pulse;
		stable_lvl  = seen_lvl;
		hist_id[wr_slot]    = next_seq;
		hist_ms[wr_slot]    = s.now_ms;
		hist_secs[wr_slot]  = s.wall;
		hist_flags[wr_slot] = f;
		next_seq = next_seq + 32'd1;
		expected_log.push_back(entry_result(KIND_EVENT, wr_slot));
		wr_slot = (wr_slot + 1) % DEPTH;
		if (held < DEPTH)
			held++;
		queue_history();
	endtask

	function automatic sample_t make_sample(logic func, logic [31:0] now_ms, logic raw,
			logic synced, logic [33:0] wall, logic relay, logic pulse);
		sample_t s;
		s.func   = func;
		s.now_ms = now_ms;
		s.raw    = raw;
		s.synced = synced;
		s.wall   = wall;
		s.relay  = relay;
		s.pulse  = pulse;
		return s;
	endfunction

	// Mostly a line that moves forward in time with glitches and held edges; the rest
	// is dump requests and samples at arbitrary times.
	function automatic sample_t next_line_sample();
		sample_t     s;
		int unsigned pick;
		int unsigned span;
		pick     = $urandom_range(0, 99);
		span     = int'(debounce_cfg) / 2 + 2;
		s.func   = FUNC_SAMPLE;
		s.synced = 1'($urandom_range(0, 1));
		s.relay  = 1'($urandom_range(0, 1));
		s.pulse  = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0)
			s.wall = floor_cfg + 34'($urandom_range(0, 4)) - 34'd2;
		else
			s.wall = {2'($urandom_range(0, 3)), 32'($urandom)};
		if (pick < 8) begin
			s.func   = FUNC_DUMP;
			s.now_ms = $urandom;
			s.raw    = 1'($urandom_range(0, 1));
		end else if (pick < 15) begin
			s.now_ms = $urandom;
			s.raw    = 1'($urandom_range(0, 1));
		end else begin
			if ($urandom_range(0, 99) < 20)
				line_target = ~line_target;
			line_clock = line_clock + 32'($urandom_range(0, span));
			s.now_ms   = line_clock;
			s.raw      = ($urandom_range(0, 99) < 8) ? ~line_target : line_target;
		end
		return s;
	endfunction

	// Offers one item, with an occasional gap, and records it once accepted.
	task automatic send_item(sample_t s);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= s.func;
		s_tdata  <= {2'b00, s.pulse, s.relay, s.wall, s.synced, s.raw, s.now_ms};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_sample(s);
	endtask

	// Stops offering and waits until every expected result has been taken.
	task automatic settle_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_log.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [33:0] value);
		settle_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_DEBOUNCE)
			debounce_cfg = value[15:0];
		else
			floor_cfg = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Dumps on an empty history; the line fields of a dump must not disturb the line.
	task automatic test_empty_dump();
		send_item(make_sample(FUNC_DUMP, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1));
		send_item(make_sample(FUNC_DUMP, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
	endtask

	// Default hold time: a short glitch, a restart of the timer, and commits with
	// the wall time at, above and below the floor.
	task automatic test_debounce_hold();
		send_item(make_sample(FUNC_SAMPLE, 32'd0,   1'b1, 1'b0, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd200, 1'b0, 1'b0, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd210, 1'b1, 1'b0, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd220, 1'b0, 1'b0, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd259, 1'b0, 1'b1, FLOOR_RESET, 1'b1, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd260, 1'b0, 1'b1, FLOOR_RESET, 1'b1, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd300, 1'b1, 1'b0, '1, 1'b0, 1'b1));
		send_item(make_sample(FUNC_SAMPLE, 32'd340, 1'b1, 1'b0, '1, 1'b0, 1'b1));
		send_item(make_sample(FUNC_SAMPLE, 32'd380, 1'b0, 1'b1, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd420, 1'b0, 1'b1, FLOOR_RESET - 34'd1,
				1'b1, 1'b1));
		send_item(make_sample(FUNC_DUMP, 32'd0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
	endtask

	// A zero hold time commits on the changing sample; the floor at both extremes.
	task automatic test_zero_debounce_and_floor();
		write_reg(REG_DEBOUNCE, 34'd0);
		write_reg(REG_TIME_FLOOR, '1);
		send_item(make_sample(FUNC_SAMPLE, 32'd1000, 1'b1, 1'b1, '1, 1'b0, 1'b0));
		write_reg(REG_TIME_FLOOR, 34'd0);
		send_item(make_sample(FUNC_SAMPLE, 32'd1001, 1'b0, 1'b1, '0, 1'b1, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'd1002, 1'b1, 1'b0, '0, 1'b0, 1'b1));
	endtask

	// Longest hold time measured across the wrap of the uptime counter.
	task automatic test_uptime_wrap();
		write_reg(REG_DEBOUNCE, 34'h0_0000_FFFF);
		send_item(make_sample(FUNC_SAMPLE, 32'hFFFF_FFF0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'h0000_FFEE, 1'b0, 1'b1, '0, 1'b0, 1'b0));
		send_item(make_sample(FUNC_SAMPLE, 32'h0000_FFEF, 1'b0, 1'b1, '0, 1'b1, 1'b1));
	endtask

	task automatic run_phase(logic [15:0] db, logic [33:0] floor_val, bit quiet, int count);
		write_reg(REG_DEBOUNCE, {18'd0, db});
		write_reg(REG_TIME_FLOOR, floor_val);
		no_idle     = quiet;
		line_clock  = $urandom;
		line_target = stable_lvl;
		repeat (count) send_item(next_line_sample());
		no_idle = 1'b0;
	endtask

	// Random traffic under several settings, one phase without any idling.
	task automatic test_random_traffic();
		run_phase(DEBOUNCE_RESET, FLOOR_RESET, 1'b0, 40);
		run_phase(16'd0, 34'd0, 1'b1, 40);
		run_phase(16'hFFFF, '1, 1'b0, 25);
		run_phase(16'($urandom_range(1, 300)), {2'($urandom_range(0, 3)), 32'($urandom)},
				1'b0, 45);
	endtask

	// The receiver holds off for a long stretch while every sample commits an edge,
	// so the block has to stall its input.
	task automatic test_backpressure();
		logic lvl;
		write_reg(REG_DEBOUNCE, 34'd0);
		lvl      = stable_lvl;
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			lvl = ~lvl;
			send_item(make_sample(FUNC_SAMPLE, $urandom, lvl, 1'($urandom_range(0, 1)),
					{2'($urandom_range(0, 3)), 32'($urandom)}, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_dump();
		test_debounce_hold();
		test_zero_debounce_and_floor();
		test_uptime_wrap();
		test_random_traffic();
		test_backpressure();
		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= no_idle || ($urandom_range(0, 99) >= 10);
		end
	end

	task automatic check_field(string name, logic [33:0] want, logic [33:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compares each result item with the oldest expectation.
	always @(posedge clk) begin
		log_result_t want;
		dbel_out_t   got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_log.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d id %0h",
						$time, m_tuser, got.seq_id);
				mismatches++;
			end else begin
				want = expected_log.pop_front();
				check_field("kind", 34'(want.kind), 34'(m_tuser));
				check_field("seq_id", 34'(want.body.seq_id), 34'(got.seq_id));
				check_field("old_level", 34'(want.body.old_level), 34'(got.old_level));
				check_field("new_level", 34'(want.body.new_level), 34'(got.new_level));
				check_field("stamp_ms", 34'(want.body.stamp_ms), 34'(got.stamp_ms));
				check_field("stamp_seconds", want.body.stamp_seconds, got.stamp_seconds);
				check_field("stamp_valid", 34'(want.body.stamp_valid), 34'(got.stamp_valid));
				check_field("relay_at_event", 34'(want.body.relay_at_event),
						34'(got.relay_at_event));
				check_field("pulse_at_event", 34'(want.body.pulse_at_event),
						34'(got.pulse_at_event));
				check_field("total_events", 34'(want.body.total_events),
						34'(got.total_events));
				check_field("stored_count", 34'(want.body.stored_count),
						34'(got.stored_count));
				check_field("last", 34'(want.last), 34'(m_tlast));
			end
		end
	end

	// Ends the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
design/dbel_pkg.sv
design/dbel_ram.sv
design/dbel_debounce.sv
design/debounced_edge_event_logger_unit.sv
tb/tb_debounced_edge_event_logger_unit.sv
